[hw/rtl/sssa_pkg.sv]
// Package for the soft shadow step accumulator: widths, reset values,
// register indexes, sequencer states and the compare-subtract result type.
// No dependencies; every other file of the block refers to it by scoped names.
package sssa_pkg;

    // Field and state widths.
    localparam int DIST_W     = 24;   // distance sample, unsigned Q8.16
    localparam int MARCH_W    = 32;   // march and previous distance
    localparam int FACTOR_W   = 17;   // factor, Q1.16
    localparam int STRENGTH_W = 16;   // light strength, Q8.8
    localparam int WIDE_W     = 48;   // square of a distance sample
    localparam int CNT_W      = 5;    // step counter of the shared unit
    localparam int REM_W      = 33;   // partial remainder
    localparam int CSUB_W     = 34;   // compare-subtract operand width
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;
    localparam logic [MARCH_W-1:0]  DIST_MAX   = 32'hFFFF_FFFF;

    // Register reset values.
    localparam logic [STRENGTH_W-1:0] LIGHT_STRENGTH_RST = 16'd4096;
    localparam logic [FACTOR_W-1:0]   SHADOW_FLOOR_RST   = 17'd13107;
    localparam logic [DIST_W-1:0]     START_OFFSET_RST   = 24'd66;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_STRENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADOW_FLOOR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_OFFSET   = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_CHK,
        ST_DIV1,
        ST_YCHK,
        ST_MUL_Y,
        ST_RAD,
        ST_SQRT,
        ST_MUL_N,
        ST_QCHK,
        ST_DIV2,
        ST_UPD,
        ST_FIN
    } state_t;

    // Result of one compare-subtract step.
    typedef struct packed {
        logic              ge;
        logic [CSUB_W-1:0] diff;
    } csub_res_t;

endpackage

[hw/rtl/sssa_csub.sv]
// Shared compare-subtract unit of the soft shadow step accumulator.
// Depends on sssa_pkg for the operand width and the result struct.
module sssa_csub
(
    input  logic [sssa_pkg::CSUB_W-1:0] a,
    input  logic [sssa_pkg::CSUB_W-1:0] b,
    output sssa_pkg::csub_res_t         res
);

    logic [sssa_pkg::CSUB_W:0] diff_ext;

    // One subtraction serves both the compare (borrow) and the new remainder.
    assign diff_ext = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~diff_ext[sssa_pkg::CSUB_W];
    assign res.diff = diff_ext[sssa_pkg::CSUB_W-1:0];

endmodule

[hw/rtl/soft_shadow_step_accumulator_core.sv]
// Soft shadow step accumulator: one lane of a soft shadow ray march.
// A finished ray goes from the input transfer straight to ST_FIN; a full step may first
// run the multiply, division and square-root states. Any output stall holds ST_FIN.
// A new item is taken only back in ST_IDLE; the shared compare-subtract unit produces
// one quotient or root bit per cycle (32 + 24 + 17 steps).
// Reset (rst_n low, asynchronous) loads the register and march reset values.
module soft_shadow_step_accumulator_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] dist_sample
    input  logic [1:0]  s_tuser,    // [0] start_ray, [1] ray_finished

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [16:0] shadow_factor, [33:17] shadow_clamped, rest zero

    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sssa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sssa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an unknown index are dropped.
    // ------------------------------------------------------------------
    logic [sssa_pkg::STRENGTH_W-1:0] light_strength_reg;
    logic [sssa_pkg::FACTOR_W-1:0]   shadow_floor_reg;
    logic [sssa_pkg::DIST_W-1:0]     start_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_strength_reg <= sssa_pkg::LIGHT_STRENGTH_RST;
            shadow_floor_reg   <= sssa_pkg::SHADOW_FLOOR_RST;
            start_offset_reg   <= sssa_pkg::START_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sssa_pkg::REG_LIGHT_STRENGTH:
                    light_strength_reg <= cfg_wdata[sssa_pkg::STRENGTH_W-1:0];
                sssa_pkg::REG_SHADOW_FLOOR:
                    shadow_floor_reg <= cfg_wdata[sssa_pkg::FACTOR_W-1:0];
                sssa_pkg::REG_START_OFFSET:
                    start_offset_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers.
    // ------------------------------------------------------------------
    sssa_pkg::state_t state_reg, state_next;

    logic [sssa_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sssa_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [31:0]                   quo_reg, quo_next;
    logic [sssa_pkg::WIDE_W-1:0]   mid_reg, mid_next;
    logic [sssa_pkg::WIDE_W-1:0]   prod_reg, prod_next;
    logic [sssa_pkg::MARCH_W-1:0]  den_reg, den_next;
    logic [sssa_pkg::DIST_W-1:0]   d_reg, d_next;
    logic                          fin_reg, fin_next;

    logic [sssa_pkg::MARCH_W-1:0]  march_reg, march_next;
    logic [sssa_pkg::MARCH_W-1:0]  prev_reg, prev_next;
    logic [sssa_pkg::FACTOR_W-1:0] factor_reg, factor_next;

    logic                          m_valid_reg, m_valid_next;
    logic [sssa_pkg::FACTOR_W-1:0] m_factor_reg, m_factor_next;
    logic [sssa_pkg::FACTOR_W-1:0] m_clamped_reg, m_clamped_next;

    // Shared multiplier: one product per cycle, always registered.
    logic [sssa_pkg::DIST_W-1:0]   mul_a, mul_b;
    logic [sssa_pkg::WIDE_W-1:0]   mul_p;

    // Shared compare-subtract unit.
    logic [sssa_pkg::CSUB_W-1:0]   csub_a, csub_b;
    sssa_pkg::csub_res_t           csub_res;

    // Helpers.
    logic [sssa_pkg::MARCH_W:0]    march_sum;
    logic [sssa_pkg::FACTOR_W-1:0] clamp_lo;
    logic [sssa_pkg::FACTOR_W-1:0] clamped;
    logic                          y_big;
    logic                          out_free;

    assign mul_p = mul_a * mul_b;

    sssa_csub u_csub
    (
        .a   (csub_a),
        .b   (csub_b),
        .res (csub_res)
    );

    assign s_tready = (state_reg == sssa_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_clamped_reg, m_factor_reg};
    assign out_free = !m_valid_reg || m_tready;

    // The march distance saturates at the largest distance.
    assign march_sum = {1'b0, march_reg} + {9'd0, d_reg};

    // The clamp keeps the floor but never lets the output rise above one.
    assign clamp_lo = (factor_reg < shadow_floor_reg) ? shadow_floor_reg : factor_reg;
    assign clamped  = (clamp_lo > sssa_pkg::FACTOR_ONE) ? sssa_pkg::FACTOR_ONE : clamp_lo;

    // y = d*d / (2*prev) does not fit in 32 bits when d*d >= prev * 2^33. Such a
    // y exceeds every march distance, so the factor stays. A zero previous
    // distance also lands here, which is the infinite-y case.
    assign y_big = (prev_reg[31:15] == 17'd0) && (mid_reg[47:33] >= prev_reg[14:0]);

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        csub_a = '0;
        csub_b = '0;
        case (state_reg)
            sssa_pkg::ST_MUL_D:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            sssa_pkg::ST_MUL_Y:
            begin
                mul_a = quo_reg[23:0];
                mul_b = quo_reg[23:0];
            end
            sssa_pkg::ST_MUL_N:
            begin
                mul_a = {8'd0, light_strength_reg};
                mul_b = quo_reg[23:0];
            end
            sssa_pkg::ST_DIV1:
            begin
                // Long division of d*d by 2*prev, one quotient bit per step.
                csub_a = {rem_reg, mid_reg[{1'b0, cnt_reg}]};
                csub_b = {1'b0, prev_reg, 1'b0};
            end
            sssa_pkg::ST_SQRT:
            begin
                // Digit-by-digit square root, two radicand bits per step.
                csub_a = {6'd0, rem_reg[25:0], mid_reg[{cnt_reg, 1'b0} +: 2]};
                csub_b = {9'd0, quo_reg[22:0], 2'b01};
            end
            sssa_pkg::ST_DIV2:
            begin
                csub_a = {rem_reg, mid_reg[{1'b0, cnt_reg}]};
                csub_b = {2'd0, den_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        mid_next       = mid_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        d_next         = d_reg;
        fin_next       = fin_reg;
        march_next     = march_reg;
        prev_next      = prev_reg;
        factor_next    = factor_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_factor_next  = m_factor_reg;
        m_clamped_next = m_clamped_reg;

        unique case (state_reg)
            sssa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    d_next   = s_tdata;
                    fin_next = s_tuser[1];
                    if (s_tuser[0])
                    begin
                        march_next  = {8'd0, start_offset_reg};
                        prev_next   = sssa_pkg::DIST_MAX;
                        factor_next = sssa_pkg::FACTOR_ONE;
                    end
                    // A finished ray skips the factor update: it only advances the march and emits the result.
                    state_next = s_tuser[1] ? sssa_pkg::ST_FIN : sssa_pkg::ST_MUL_D;
                end
            end

            sssa_pkg::ST_MUL_D:
            begin
                mid_next   = mul_p;
                state_next = sssa_pkg::ST_CHK;
            end

            sssa_pkg::ST_CHK:
            begin
                if (y_big)
                begin
                    state_next = sssa_pkg::ST_FIN;
                end
                else
                begin
                    // The quotient fits in 32 bits, so the top 16 bits of
                    // the dividend already sit below the divisor.
                    rem_next   = {17'd0, mid_reg[47:32]};
                    quo_next   = '0;
                    cnt_next   = 5'd31;
                    state_next = sssa_pkg::ST_DIV1;
                end
            end

            sssa_pkg::ST_DIV1,
            sssa_pkg::ST_SQRT,
            sssa_pkg::ST_DIV2:
            begin
                quo_next = {quo_reg[30:0], csub_res.ge};
                rem_next = csub_res.ge ? csub_res.diff[sssa_pkg::REM_W-1:0]
                                       : csub_a[sssa_pkg::REM_W-1:0];
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    if (state_reg == sssa_pkg::ST_DIV1)
                        state_next = sssa_pkg::ST_YCHK;
                    else if (state_reg == sssa_pkg::ST_SQRT)
                        state_next = sssa_pkg::ST_MUL_N;
                    else
                        state_next = sssa_pkg::ST_UPD;
                end
            end

            sssa_pkg::ST_YCHK:
            begin
                if (march_reg <= quo_reg)
                begin
                    // The divisor would be zero or negative: factor stays.
                    state_next = sssa_pkg::ST_FIN;
                end
                else
                begin
                    den_next = march_reg - quo_reg;
                    if (quo_reg > {8'd0, d_reg})
                    begin
                        // Negative radicand: the chord is zero.
                        quo_next   = '0;
                        state_next = sssa_pkg::ST_MUL_N;
                    end
                    else
                    begin
                        state_next = sssa_pkg::ST_MUL_Y;
                    end
                end
            end

            sssa_pkg::ST_MUL_Y:
            begin
                prod_next  = mul_p;
                state_next = sssa_pkg::ST_RAD;
            end

            sssa_pkg::ST_RAD:
            begin
                mid_next   = mid_reg - prod_reg;
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = 5'd23;
                state_next = sssa_pkg::ST_SQRT;
            end

            sssa_pkg::ST_MUL_N:
            begin
                prod_next  = mul_p;
                state_next = sssa_pkg::ST_QCHK;
            end

            sssa_pkg::ST_QCHK:
            begin
                // The quotient strength*h*256/den only matters below 2^17,
                // because the factor never exceeds one.
                if ({1'b0, prod_reg[39:0]} >= {den_reg, 9'd0})
                begin
                    state_next = sssa_pkg::ST_FIN;
                end
                else
                begin
                    mid_next   = {prod_reg[39:0], 8'd0};
                    rem_next   = {2'd0, prod_reg[39:9]};
                    quo_next   = '0;
                    cnt_next   = 5'd16;
                    state_next = sssa_pkg::ST_DIV2;
                end
            end

            sssa_pkg::ST_UPD:
            begin
                if (quo_reg[16:0] < factor_reg)
                    factor_next = quo_reg[16:0];
                state_next = sssa_pkg::ST_FIN;
            end

            sssa_pkg::ST_FIN:
            begin
                // Wait for the output register to free before advancing
                // the march, so the update happens exactly once.
                if (out_free)
                begin
                    prev_next      = {8'd0, d_reg};
                    march_next     = march_sum[sssa_pkg::MARCH_W] ? sssa_pkg::DIST_MAX
                                                                  : march_sum[31:0];
                    m_valid_next   = 1'b1;
                    m_factor_next  = factor_reg;
                    m_clamped_next = clamped;
                    state_next     = sssa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sssa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and march state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sssa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            march_reg   <= {8'd0, sssa_pkg::START_OFFSET_RST};
            prev_reg    <= sssa_pkg::DIST_MAX;
            factor_reg  <= sssa_pkg::FACTOR_ONE;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            march_reg   <= march_next;
            prev_reg    <= prev_next;
            factor_reg  <= factor_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        mid_reg       <= mid_next;
        prod_reg      <= prod_next;
        den_reg       <= den_next;
        d_reg         <= d_next;
        fin_reg       <= fin_next;
        m_factor_reg  <= m_factor_next;
        m_clamped_reg <= m_clamped_next;
    end

`ifndef SYNTHESIS
    // A running factor above one would mean the minimum was taken wrongly.
    a_factor_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        factor_reg <= sssa_pkg::FACTOR_ONE)
        else $error("shadow factor above one");

    // A transfer on the input always starts work on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != sssa_pkg::ST_IDLE))
        else $error("sequencer idle after input transfer");

    // The first division keeps its remainder below the divisor.
    a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sssa_pkg::ST_DIV1) |-> ({1'b0, rem_reg} < {1'b0, prev_reg, 1'b0}))
        else $error("first division remainder out of range");

    // A finished ray never reaches the factor update.
    a_finished_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sssa_pkg::ST_UPD) |-> !fin_reg)
        else $error("factor update on a finished ray");

    // The clamped result never exceeds one.
    a_clamp_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_clamped_reg <= sssa_pkg::FACTOR_ONE))
        else $error("clamped output above one");
`endif

endmodule
